// File: sv/nco_pkg.sv
`default_nettype none

package nco_pkg;

    // configuration port
    localparam int CFG_INDEX_BITS = 1;
    localparam int CFG_DATA_BITS  = 32;
    localparam int FREQ_STEP_BITS = 32;

    typedef logic [CFG_INDEX_BITS-1:0] cfg_index_t;

    localparam cfg_index_t CFG_FREQ_STEP = 1'b0;
    localparam cfg_index_t CFG_MODE      = 1'b1;

    typedef enum logic {
        MODE_GENERATE = 1'b0,
        MODE_MIX      = 1'b1
    } nco_mode_t;

    // quadrant of the phase, top two phase bits
    typedef enum logic [1:0] {
        QUAD_0 = 2'd0,
        QUAD_1 = 2'd1,
        QUAD_2 = 2'd2,
        QUAD_3 = 2'd3
    } nco_quad_t;

    // stage advance strobes handed to the mixer datapath
    typedef struct packed {
        logic prod;
        logic res;
    } nco_adv_t;

    // stages between an accepted request and its result
    localparam int PIPE_DEPTH = 3;

    // pi/2 in Q30
    localparam logic [63:0] Q30_HALF_PI = 64'd1686629713;

    // taylor series divisors (2n)(2n+1) for n = 1..7
    localparam int SERIES_TERMS = 7;
    localparam logic [63:0] SERIES_DIV [SERIES_TERMS] =
        '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210};

    // sin of a Q30 angle in [0, pi/2], elaboration time only
    function automatic logic [63:0] sin_q30(input logic [63:0] x);
        logic [63:0] term;
        logic [63:0] sum;
        term = x;
        sum  = x;
        for (int n = 0; n < SERIES_TERMS; n++) begin
            term = (term * x) >> 30;
            term = (term * x) >> 30;
            term = term / SERIES_DIV[n];
            if (!n[0])
                sum = sum - term;
            else
                sum = sum + term;
        end
        return sum;
    endfunction

endpackage

`default_nettype wire

// File: sv/nco_in_if.sv
`default_nettype none

interface nco_in_if #(
    parameter int SAMPLE_BITS = 16
) ();
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] in_re;
    logic signed [SAMPLE_BITS-1:0] in_im;
    logic                          last;

    modport source (output valid, output in_re, output in_im, output last, input ready);
    modport sink   (input valid, input in_re, input in_im, input last, output ready);
endinterface

`default_nettype wire

// File: sv/nco_out_if.sv
`default_nettype none

interface nco_out_if #(
    parameter int SAMPLE_BITS = 16
) ();
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] out_re;
    logic signed [SAMPLE_BITS-1:0] out_im;
    logic                          out_last;

    modport source (output valid, output out_re, output out_im, output out_last, input ready);
    modport sink   (input valid, input out_re, input out_im, input out_last, output ready);
endinterface

`default_nettype wire

// File: sv/nco_sin_rom.sv
`default_nettype none

module nco_sin_rom
    import nco_pkg::*;
#(
    parameter int TABLE_ADDR_BITS = 10,
    parameter int SAMPLE_BITS     = 16
)
(
    input  wire logic                       clk,
    input  wire logic                       en,
    input  wire logic [TABLE_ADDR_BITS:0]   addr_a,
    input  wire logic [TABLE_ADDR_BITS:0]   addr_b,
    output logic      [SAMPLE_BITS-2:0]     data_a,
    output logic      [SAMPLE_BITS-2:0]     data_b
);

    localparam int TBL_N  = 2 ** TABLE_ADDR_BITS;
    localparam int HALF_N = TBL_N / 2;
    localparam int DEPTH  = TBL_N + 1;
    localparam int AMP    = (2 ** (SAMPLE_BITS - 1)) - 1;

    typedef logic [SAMPLE_BITS-2:0] entry_t;
    typedef entry_t rom_t [DEPTH];

    // quarter-wave sine, rounded half up and clamped to the amplitude
    function automatic rom_t build_table();
        rom_t        tbl;
        logic [63:0] x;
        logic [63:0] s;
        logic [63:0] v;
        for (int k = 0; k < DEPTH; k++) begin
            x = (64'(k) * Q30_HALF_PI + 64'(HALF_N)) >> TABLE_ADDR_BITS;
            s = sin_q30(x);
            v = (s * 64'(AMP) + (64'd1 << 29)) >> 30;
            if (v > 64'(AMP))
                v = 64'(AMP);
            tbl[k] = v[SAMPLE_BITS-2:0];
        end
        return tbl;
    endfunction

    localparam rom_t SINE_ROM = build_table();

    logic [SAMPLE_BITS-2:0] data_a_reg;
    logic [SAMPLE_BITS-2:0] data_b_reg;

    // two registered read ports
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_a_reg <= SINE_ROM[addr_a];
            data_b_reg <= SINE_ROM[addr_b];
        end
    end

    assign data_a = data_a_reg;
    assign data_b = data_b_reg;

endmodule

`default_nettype wire

// File: sv/nco_cmul.sv
`default_nettype none

module nco_cmul
    import nco_pkg::*;
#(
    parameter int SAMPLE_BITS = 16
)
(
    input  wire logic                          clk,
    input  wire nco_adv_t                      adv,
    input  wire nco_mode_t                     mode,
    input  wire nco_quad_t                     quad,
    input  wire logic        [SAMPLE_BITS-2:0] a_mag,
    input  wire logic        [SAMPLE_BITS-2:0] b_mag,
    input  wire logic signed [SAMPLE_BITS-1:0] xr,
    input  wire logic signed [SAMPLE_BITS-1:0] xi,
    input  wire logic                          last,
    output logic signed      [SAMPLE_BITS-1:0] out_re,
    output logic signed      [SAMPLE_BITS-1:0] out_im,
    output logic                               out_last
);

    localparam int PROD_W = 2 * SAMPLE_BITS;
    localparam int SUM_W  = 2 * SAMPLE_BITS + 2;

    localparam logic signed [SUM_W-1:0] ROUND_HALF = SUM_W'(1) << (SAMPLE_BITS - 2);
    localparam logic signed [SUM_W-1:0] SAT_MAX    = SUM_W'((1 << (SAMPLE_BITS - 1)) - 1);
    localparam logic signed [SUM_W-1:0] SAT_MIN    = ~SAT_MAX;
    localparam logic signed [SAMPLE_BITS-1:0] OUT_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [SAMPLE_BITS-1:0] OUT_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    // floor shift back to Q1.15 and clamp
    function automatic logic signed [SAMPLE_BITS-1:0] round_sat(
        input logic signed [SUM_W-1:0] v
    );
        logic signed [SUM_W-1:0] sh;
        sh = v >>> (SAMPLE_BITS - 1);
        priority if (sh > SAT_MAX)
            return OUT_MAX;
        else if (sh < SAT_MIN)
            return OUT_MIN;
        else
            return sh[SAMPLE_BITS-1:0];
    endfunction

    logic signed [SAMPLE_BITS-1:0] a_val;
    logic signed [SAMPLE_BITS-1:0] b_val;
    logic signed [SAMPLE_BITS-1:0] cos_v;
    logic signed [SAMPLE_BITS-1:0] sin_v;

    logic signed [PROD_W-1:0]      p_rc_reg;
    logic signed [PROD_W-1:0]      p_is_reg;
    logic signed [PROD_W-1:0]      p_rs_reg;
    logic signed [PROD_W-1:0]      p_ic_reg;
    logic signed [SAMPLE_BITS-1:0] cos_reg;
    logic signed [SAMPLE_BITS-1:0] sin_reg;
    logic                          last_reg;

    logic signed [SUM_W-1:0]       re_sum;
    logic signed [SUM_W-1:0]       im_sum;

    logic signed [SAMPLE_BITS-1:0] out_re_reg;
    logic signed [SAMPLE_BITS-1:0] out_im_reg;
    logic                          out_last_reg;

    assign a_val = signed'({1'b0, a_mag});
    assign b_val = signed'({1'b0, b_mag});

    // quadrant fold of the quarter-wave values
    always_comb
    begin
        unique case (quad)
            QUAD_0:
            begin
                cos_v = b_val;
                sin_v = a_val;
            end
            QUAD_1:
            begin
                cos_v = -a_val;
                sin_v = b_val;
            end
            QUAD_2:
            begin
                cos_v = -b_val;
                sin_v = -a_val;
            end
            QUAD_3:
            begin
                cos_v = a_val;
                sin_v = -b_val;
            end
            default:
            begin
                cos_v = b_val;
                sin_v = a_val;
            end
        endcase
    end

    // partial products of the complex multiply
    always_ff @(posedge clk)
    begin
        if (adv.prod)
        begin
            p_rc_reg <= PROD_W'(xr) * PROD_W'(cos_v);
            p_is_reg <= PROD_W'(xi) * PROD_W'(sin_v);
            p_rs_reg <= PROD_W'(xr) * PROD_W'(sin_v);
            p_ic_reg <= PROD_W'(xi) * PROD_W'(cos_v);
            cos_reg  <= cos_v;
            sin_reg  <= sin_v;
            last_reg <= last;
        end
    end

    // sums with the half-lsb rounding constant
    assign re_sum = SUM_W'(p_rc_reg) - SUM_W'(p_is_reg) + ROUND_HALF;
    assign im_sum = SUM_W'(p_rs_reg) + SUM_W'(p_ic_reg) + ROUND_HALF;

    // result register
    always_ff @(posedge clk)
    begin
        if (adv.res)
        begin
            if (mode == MODE_MIX)
            begin
                out_re_reg <= round_sat(re_sum);
                out_im_reg <= round_sat(im_sum);
            end
            else
            begin
                out_re_reg <= cos_reg;
                out_im_reg <= sin_reg;
            end
            out_last_reg <= last_reg;
        end
    end

    assign out_re   = out_re_reg;
    assign out_im   = out_im_reg;
    assign out_last = out_last_reg;

endmodule

`default_nettype wire

// File: sv/nco_phase_accumulator_mixer_top.sv
`default_nettype none

// channel  | dir | payload                    | transfer
// ---------+-----+----------------------------+--------------------
// samples  | in  | in_re, in_im, last         | valid && ready
// results  | out | out_re, out_im, out_last   | valid && ready
// cfg      | in  | cfg_index, cfg_data        | cfg_wr_en high
//
// one request per clock while results are not stalled; its result passes the
// table read, product and result registers before it becomes valid
// stages: dual-port sine table read, four registered products, round/saturate
// the phase advances on each accept; the table is a constant rom, no clear pass
// rst_n clears freq_step, mode, phase and the stage valid bits
// a stall on results fills empty stages first, then drops samples.ready

module nco_phase_accumulator_mixer_top
    import nco_pkg::*;
#(
    parameter int PHASE_BITS      = 32,
    parameter int TABLE_ADDR_BITS = 10,
    parameter int SAMPLE_BITS     = 16
)
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     cfg_wr_en,
    input  wire cfg_index_t               cfg_index,
    input  wire logic [CFG_DATA_BITS-1:0] cfg_data,
    nco_in_if.sink                        samples,
    nco_out_if.source                     results
);

    logic signed [FREQ_STEP_BITS-1:0]  freq_step_reg;
    nco_mode_t                         mode_reg;
    logic        [PHASE_BITS-1:0]      phase_acc_reg;
    logic        [PHASE_BITS-1:0]      step_scaled;

    logic                              adv_s1;
    nco_adv_t                          adv;
    logic                              in_fire;

    logic                              v_s1_reg;
    logic                              v_s2_reg;
    logic                              v_out_reg;

    nco_quad_t                         quad;
    logic        [TABLE_ADDR_BITS-1:0] idx;
    logic        [TABLE_ADDR_BITS:0]   addr_a;
    logic        [TABLE_ADDR_BITS:0]   addr_b;
    logic        [SAMPLE_BITS-2:0]     a_mag;
    logic        [SAMPLE_BITS-2:0]     b_mag;

    nco_quad_t                         quad_s1_reg;
    logic signed [SAMPLE_BITS-1:0]     re_s1_reg;
    logic signed [SAMPLE_BITS-1:0]     im_s1_reg;
    logic                              last_s1_reg;

    localparam logic [TABLE_ADDR_BITS:0] TBL_SIZE = {1'b1, {TABLE_ADDR_BITS{1'b0}}};

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            freq_step_reg <= '0;
            mode_reg      <= MODE_GENERATE;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_FREQ_STEP: freq_step_reg <= signed'(cfg_data[FREQ_STEP_BITS-1:0]);
                CFG_MODE:      mode_reg      <= nco_mode_t'(cfg_data[0]);
                default:       ;
            endcase
        end
    end

    // step rescaled to the accumulator width
    if (PHASE_BITS >= FREQ_STEP_BITS)
    begin : g_step_up
        assign step_scaled = PHASE_BITS'(freq_step_reg) << (PHASE_BITS - FREQ_STEP_BITS);
    end
    else
    begin : g_step_down
        assign step_scaled = freq_step_reg[FREQ_STEP_BITS-1 -: PHASE_BITS];
    end

    // stage handshake, each stage loads when empty or draining
    assign adv.res  = !v_out_reg || results.ready;
    assign adv.prod = !v_s2_reg || adv.res;
    assign adv_s1   = !v_s1_reg || adv.prod;
    assign in_fire  = samples.valid && adv_s1;

    assign samples.ready = adv_s1;
    assign results.valid = v_out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_s1_reg  <= 1'b0;
            v_s2_reg  <= 1'b0;
            v_out_reg <= 1'b0;
        end
        else
        begin
            if (adv_s1)
                v_s1_reg <= samples.valid;
            if (adv.prod)
                v_s2_reg <= v_s1_reg;
            if (adv.res)
                v_out_reg <= v_s2_reg;
        end
    end

    // phase accumulator, wraps modulo its width
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            phase_acc_reg <= '0;
        else if (in_fire)
            phase_acc_reg <= phase_acc_reg + step_scaled;
    end

    // table addresses from the truncated phase
    assign quad   = nco_quad_t'(phase_acc_reg[PHASE_BITS-1 -: 2]);
    assign idx    = phase_acc_reg[PHASE_BITS-3 -: TABLE_ADDR_BITS];
    assign addr_a = {1'b0, idx};
    assign addr_b = TBL_SIZE - {1'b0, idx};

    nco_sin_rom #(
        .TABLE_ADDR_BITS (TABLE_ADDR_BITS),
        .SAMPLE_BITS     (SAMPLE_BITS)
    ) u_sin_rom (
        .clk    (clk),
        .en     (adv_s1),
        .addr_a (addr_a),
        .addr_b (addr_b),
        .data_a (a_mag),
        .data_b (b_mag)
    );

    // sample and quadrant aligned with the table read
    always_ff @(posedge clk)
    begin
        if (adv_s1)
        begin
            quad_s1_reg <= quad;
            re_s1_reg   <= samples.in_re;
            im_s1_reg   <= samples.in_im;
            last_s1_reg <= samples.last;
        end
    end

    nco_cmul #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_cmul (
        .clk      (clk),
        .adv      (adv),
        .mode     (mode_reg),
        .quad     (quad_s1_reg),
        .a_mag    (a_mag),
        .b_mag    (b_mag),
        .xr       (re_s1_reg),
        .xi       (im_s1_reg),
        .last     (last_s1_reg),
        .out_re   (results.out_re),
        .out_im   (results.out_im),
        .out_last (results.out_last)
    );

endmodule

`default_nettype wire

// File: sv/nco_checker.sv
`default_nettype none

module nco_checker
    import nco_pkg::*;
#(
    parameter int SAMPLE_BITS = 16
)
(
    input wire logic                   clk,
    input wire logic                   rst_n,
    input wire logic                   in_valid,
    input wire logic                   in_ready,
    input wire logic                   out_valid,
    input wire logic                   out_ready,
    input wire logic [SAMPLE_BITS-1:0] out_re,
    input wire logic [SAMPLE_BITS-1:0] out_im,
    input wire logic                   out_last
);

    localparam int CNT_W = $clog2(PIPE_DEPTH + 2);

    logic             in_fire;
    logic             out_fire;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign in_fire  = in_valid && in_ready;
    assign out_fire = out_valid && out_ready;

    // requests accepted but not yet delivered
    always_comb
    begin
        count_next = count_reg;
        if (in_fire && !out_fire)
            count_next = count_reg + CNT_W'(1);
        else if (!in_fire && out_fire)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else
            count_reg <= count_next;
    end

    // never more in flight than the pipeline holds
    a_depth: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(PIPE_DEPTH))
        else $error("more requests in flight than pipeline stages");

    // every result belongs to an accepted request
    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> count_reg != '0)
        else $error("result without an outstanding request");

    // a stalled result holds its value
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable({out_re, out_im, out_last}))
        else $error("stalled result changed");

    // reset empties the result register
    a_reset: assert property (@(posedge clk)
        !rst_n |-> !out_valid)
        else $error("result valid during reset");

endmodule

bind nco_phase_accumulator_mixer_top nco_checker #(
    .SAMPLE_BITS (SAMPLE_BITS)
) u_nco_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (samples.valid),
    .in_ready  (samples.ready),
    .out_valid (results.valid),
    .out_ready (results.ready),
    .out_re    (results.out_re),
    .out_im    (results.out_im),
    .out_last  (results.out_last)
);

`default_nettype wire
